>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define BDLL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Checked on every clock edge, reset included.
`define BDLL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");
`else
`define BDLL_ASSERT(lbl, prop)
`define BDLL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/bdll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdll_pkg;

  localparam int SLOTS = 1024;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 11;
  localparam int HDL_W = 10;
  localparam int CNT_W = 11;
  localparam int ST_W  = 3;
  localparam int CAP_W = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_FRONT  = 3'd0,
    OP_BACK   = 3'd1,
    OP_AT_POS = 3'd2,
    OP_AFTER  = 3'd3,
    OP_BEFORE = 3'd4,
    OP_DELETE = 3'd5,
    OP_SEARCH = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_POS      = 3'd2,
    ST_HANDLE   = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_NULL     = 3'd6
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
    logic [HDL_W-1:0]        handle_in;
  } req_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [HDL_W-1:0] handle_out;
    logic             handle_valid;
    logic [CNT_W-1:0] list_count;
  } rsp_item_t;

endpackage

`default_nettype wire

>>> rtl/bdll_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdll_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/bounded_doubly_linked_list_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Bounded doubly linked list. Entries (value, next, prev, in-use) live in a
// node RAM of SLOTS words; free slots sit on a free stack RAM. One request
// item gives one response item (status, handle, count). Both RAMs have one
// read and one write port with a registered read, and every link hop costs
// one node RAM read. An insert pops a slot off the free stack, writes the
// new entry and patches the links of its neighbors; an insert at a position
// not at either end first walks from the head. Search and delete walk from
// the head, visiting at most every entry in the list, and a delete then
// relinks the neighbors of the freed slot. One item is in work at a time;
// the next request is taken while a response still waits on rsp_o.
// No clearing pass runs after reset: a low-water mark on the free stack tells
// which slots were ever handed out, so the block is ready right after reset.
// The capacity register is written through cfg_we_i / cfg_data_i; the user
// must write it only while idle, the block itself does not enforce it.
module bounded_doubly_linked_list_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bdll_pkg::CAP_W-1:0] cfg_data_i,
  bdll_stream_if.sink                req_i,
  bdll_stream_if.source              rsp_o
);
  import bdll_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IW-1:0]    nxt;
    logic [IW-1:0]    prv;
    logic             used;
  } node_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CHK  = 10'b0000000010,  // handle entry read back, check in-use
    S_WALK = 10'b0000000100,  // position walk, one hop per cycle
    S_SRCH = 10'b0000001000,  // value search, one hop per cycle
    S_POP  = 10'b0000010000,  // read free stack top
    S_POPW = 10'b0000100000,  // new slot known, start relink
    S_A1   = 10'b0001000000,  // reference entry read, patch its next
    S_RMW  = 10'b0010000000,  // patch one link of the entry read back
    S_WNEW = 10'b0100000000,  // write new entry in the middle of the list
    S_DONE = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    LK_FRONT,
    LK_BACK,
    LK_AFTER
  } link_e;

  typedef enum logic [1:0] {
    HS_NONE,
    HS_SLOT,
    HS_HEAD
  } hsel_e;

  // control state
  state_e           state_q, state_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    ftop_q, ftop_d;
  logic [CW-1:0]    lw_q, lw_d;       // free stack entries below this are untouched
  logic             out_valid_q, out_valid_d;
  logic             sec_q, sec_d;     // a second link patch is pending
  logic             wnew_q, wnew_d;   // new entry still to be written

  // per-item working registers
  logic [VAL_W-1:0] val_q, val_d;
  logic [IW-1:0]    hin_q, hin_d;
  logic             before_q, before_d;
  logic             del_q, del_d;
  logic [IW-1:0]    s_q, s_d;
  logic [IW-1:0]    ref_q, ref_d;
  logic [IW-1:0]    nb_q, nb_d;
  logic [CW-1:0]    steps_q, steps_d;
  logic [CW-1:0]    hops_q, hops_d;
  link_e            lk_q, lk_d;
  hsel_e            hsel_q, hsel_d;
  status_e          st_q, st_d;
  logic             rmw_nxt_q, rmw_nxt_d;
  logic [IW-1:0]    rmw_val_q, rmw_val_d;
  logic [IW-1:0]    sec_addr_q, sec_addr_d;
  logic             sec_nxt_q, sec_nxt_d;
  logic [IW-1:0]    sec_val_q, sec_val_d;
  rsp_item_t        out_q, out_d;
  logic [IW-1:0]    raddr_q;
  logic             rvalid_q;

  // node RAM port
  logic             nm_we, nm_re;
  logic [IW-1:0]    nm_waddr, nm_raddr;
  node_t            nm_wdata, nm_rdata;

  // free stack RAM
  logic [IW-1:0]    fs_mem_q [SLOTS];
  logic [IW-1:0]    fs_rdata_q;
  logic             fs_we, fs_re;
  logic [IW-1:0]    fs_waddr, fs_raddr, fs_wdata;

  // helpers
  logic             list_full;
  logic             hin_in_range;
  logic [CW-1:0]    pop_idx;
  logic             pop_fresh;
  logic [IW-1:0]    pop_slot;
  link_e            lk_eff;
  node_t            rmw_word;
  logic             hvalid;
  logic [IW-1:0]    hout;

  bdll_node_mem #(
    .DEPTH (SLOTS),
    .word_t(node_t)
  ) u_node_mem (
    .clk_i  (clk_i),
    .we_i   (nm_we),
    .waddr_i(nm_waddr),
    .wdata_i(nm_wdata),
    .re_i   (nm_re),
    .raddr_i(nm_raddr),
    .rdata_o(nm_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem_q[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rdata_q <= fs_mem_q[fs_raddr];
    end
  end

  assign list_full    = (32'(cnt_q) >= 32'(cap_q)) || (ftop_q == '0);
  assign hin_in_range = 32'(req_i.payload.handle_in) < SLOTS;
  assign pop_idx      = ftop_q - CW'(1);
  assign pop_fresh    = pop_idx < lw_q;
  // untouched stack entry i holds slot SLOTS-1-i
  assign pop_slot     = pop_fresh ? IW'(SLOTS - 1 - 32'(pop_idx)) : fs_rdata_q;
  assign lk_eff       = ((lk_q == LK_AFTER) && (ref_q == tail_q)) ? LK_BACK : lk_q;

  always_comb begin
    rmw_word = nm_rdata;
    if (rmw_nxt_q) begin
      rmw_word.nxt = rmw_val_q;
    end else begin
      rmw_word.prv = rmw_val_q;
    end
  end

  always_comb begin
    case (hsel_q)
      HS_SLOT: begin
        hvalid = 1'b1;
        hout   = s_q;
      end
      HS_HEAD: begin
        hvalid = (cnt_q != '0);
        hout   = head_q;
      end
      default: begin
        hvalid = 1'b0;
        hout   = '0;
      end
    endcase
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d     = state_q;
    cap_d       = cfg_we_i ? cfg_data_i : cap_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    ftop_d      = ftop_q;
    lw_d        = lw_q;
    out_valid_d = out_valid_q;
    sec_d       = sec_q;
    wnew_d      = wnew_q;
    val_d       = val_q;
    hin_d       = hin_q;
    before_d    = before_q;
    del_d       = del_q;
    s_d         = s_q;
    ref_d       = ref_q;
    nb_d        = nb_q;
    steps_d     = steps_q;
    hops_d      = hops_q;
    lk_d        = lk_q;
    hsel_d      = hsel_q;
    st_d        = st_q;
    rmw_nxt_d   = rmw_nxt_q;
    rmw_val_d   = rmw_val_q;
    sec_addr_d  = sec_addr_q;
    sec_nxt_d   = sec_nxt_q;
    sec_val_d   = sec_val_q;
    out_d       = out_q;

    nm_we    = 1'b0;
    nm_waddr = '0;
    nm_wdata = '0;
    nm_re    = 1'b0;
    nm_raddr = '0;
    fs_we    = 1'b0;
    fs_waddr = '0;
    fs_wdata = '0;
    fs_re    = 1'b0;
    fs_raddr = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          val_d    = req_i.payload.item_value;
          hin_d    = IW'(req_i.payload.handle_in);
          st_d     = ST_OK;
          hsel_d   = HS_NONE;
          sec_d    = 1'b0;
          wnew_d   = 1'b0;
          state_d  = S_DONE;
          case (op_e'(req_i.payload.op))
            OP_FRONT, OP_BACK: begin
              if (list_full) begin
                st_d = ST_FULL;
              end else begin
                lk_d    = (op_e'(req_i.payload.op) == OP_FRONT) ? LK_FRONT : LK_BACK;
                state_d = S_POP;
              end
            end
            OP_AT_POS: begin
              if (list_full) begin
                st_d = ST_FULL;
              end else if (32'(req_i.payload.position) > 32'(cnt_q)) begin
                st_d = ST_POS;
              end else if (req_i.payload.position == '0) begin
                lk_d    = LK_FRONT;
                state_d = S_POP;
              end else if (32'(req_i.payload.position) == 32'(cnt_q)) begin
                lk_d    = LK_BACK;
                state_d = S_POP;
              end else if (req_i.payload.position == POS_W'(1)) begin
                ref_d   = head_q;
                lk_d    = LK_AFTER;
                state_d = S_POP;
              end else begin
                nm_re    = 1'b1;
                nm_raddr = head_q;
                steps_d  = CW'(req_i.payload.position) - CW'(1);
                state_d  = S_WALK;
              end
            end
            OP_AFTER, OP_BEFORE: begin
              before_d = (op_e'(req_i.payload.op) == OP_BEFORE);
              if (list_full) begin
                st_d = ST_FULL;
              end else if ((op_e'(req_i.payload.op) == OP_BEFORE) && (cnt_q == '0)) begin
                // empty list: the handle is ignored
                lk_d    = LK_BACK;
                state_d = S_POP;
              end else if (!hin_in_range) begin
                st_d = ST_HANDLE;
              end else begin
                nm_re    = 1'b1;
                nm_raddr = IW'(req_i.payload.handle_in);
                state_d  = S_CHK;
              end
            end
            OP_DELETE: begin
              del_d = 1'b1;
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else if (req_i.payload.item_value == '0) begin
                st_d   = ST_NULL;
                hsel_d = HS_HEAD;
              end else begin
                nm_re    = 1'b1;
                nm_raddr = head_q;
                hops_d   = '0;
                state_d  = S_SRCH;
              end
            end
            OP_SEARCH: begin
              del_d = 1'b0;
              if (cnt_q == '0) begin
                st_d = ST_NOTFOUND;
              end else begin
                nm_re    = 1'b1;
                nm_raddr = head_q;
                hops_d   = '0;
                state_d  = S_SRCH;
              end
            end
            default: begin
              st_d = ST_OK;
            end
          endcase
        end
      end

      S_CHK: begin
        if (!(rvalid_q && nm_rdata.used)) begin
          st_d    = ST_HANDLE;
          state_d = S_DONE;
        end else if (before_q) begin
          if (hin_q == head_q) begin
            lk_d = LK_FRONT;
          end else begin
            ref_d = nm_rdata.prv;
            lk_d  = LK_AFTER;
          end
          state_d = S_POP;
        end else begin
          ref_d   = hin_q;
          lk_d    = LK_AFTER;
          state_d = S_POP;
        end
      end

      S_WALK: begin
        if (steps_q == CW'(1)) begin
          ref_d   = nm_rdata.nxt;
          lk_d    = LK_AFTER;
          state_d = S_POP;
        end else begin
          nm_re    = 1'b1;
          nm_raddr = nm_rdata.nxt;
          steps_d  = steps_q - CW'(1);
        end
      end

      S_SRCH: begin
        if (nm_rdata.value == val_q) begin
          s_d = raddr_q;
          if (!del_q) begin
            hsel_d  = HS_SLOT;
            state_d = S_DONE;
          end else begin
            // free the slot and relink its neighbors
            hsel_d   = HS_HEAD;
            nm_we    = 1'b1;
            nm_waddr = raddr_q;
            nm_wdata = nm_rdata;
            nm_wdata.used = 1'b0;
            if (32'(ftop_q) < SLOTS) begin
              fs_we    = 1'b1;
              fs_waddr = ftop_q[IW-1:0];
              fs_wdata = raddr_q;
              ftop_d   = ftop_q + CW'(1);
            end
            cnt_d = cnt_q - CW'(1);
            if (cnt_q <= CW'(1)) begin
              head_d  = '0;
              tail_d  = '0;
              state_d = S_DONE;
            end else if (raddr_q == head_q) begin
              head_d    = nm_rdata.nxt;
              nm_re     = 1'b1;
              nm_raddr  = nm_rdata.nxt;
              rmw_nxt_d = 1'b0;
              rmw_val_d = '0;
              state_d   = S_RMW;
            end else if (raddr_q == tail_q) begin
              tail_d    = nm_rdata.prv;
              nm_re     = 1'b1;
              nm_raddr  = nm_rdata.prv;
              rmw_nxt_d = 1'b1;
              rmw_val_d = '0;
              state_d   = S_RMW;
            end else begin
              nm_re      = 1'b1;
              nm_raddr   = nm_rdata.prv;
              rmw_nxt_d  = 1'b1;
              rmw_val_d  = nm_rdata.nxt;
              sec_d      = 1'b1;
              sec_addr_d = nm_rdata.nxt;
              sec_nxt_d  = 1'b0;
              sec_val_d  = nm_rdata.prv;
              state_d    = S_RMW;
            end
          end
        end else if ((hops_q + CW'(1)) == cnt_q) begin
          st_d    = ST_NOTFOUND;
          hsel_d  = del_q ? HS_HEAD : HS_NONE;
          state_d = S_DONE;
        end else begin
          nm_re    = 1'b1;
          nm_raddr = nm_rdata.nxt;
          hops_d   = hops_q + CW'(1);
        end
      end

      S_POP: begin
        fs_re    = 1'b1;
        fs_raddr = pop_idx[IW-1:0];
        state_d  = S_POPW;
      end

      S_POPW: begin
        s_d    = pop_slot;
        hsel_d = HS_SLOT;
        ftop_d = pop_idx;
        if (pop_fresh) begin
          lw_d = pop_idx;
        end
        cnt_d = cnt_q + CW'(1);
        case (lk_eff)
          LK_FRONT, LK_BACK: begin
            nm_we    = 1'b1;
            nm_waddr = pop_slot;
            nm_wdata.value = val_q;
            nm_wdata.used  = 1'b1;
            if (cnt_q == '0) begin
              head_d  = pop_slot;
              tail_d  = pop_slot;
              state_d = S_DONE;
            end else if (lk_eff == LK_FRONT) begin
              nm_wdata.nxt = head_q;
              nm_re        = 1'b1;
              nm_raddr     = head_q;
              rmw_nxt_d    = 1'b0;
              rmw_val_d    = pop_slot;
              head_d       = pop_slot;
              state_d      = S_RMW;
            end else begin
              nm_wdata.prv = tail_q;
              nm_re        = 1'b1;
              nm_raddr     = tail_q;
              rmw_nxt_d    = 1'b1;
              rmw_val_d    = pop_slot;
              tail_d       = pop_slot;
              state_d      = S_RMW;
            end
          end
          default: begin
            nm_re    = 1'b1;
            nm_raddr = ref_q;
            state_d  = S_A1;
          end
        endcase
      end

      S_A1: begin
        nm_we        = 1'b1;
        nm_waddr     = raddr_q;
        nm_wdata     = nm_rdata;
        nm_wdata.nxt = s_q;
        nb_d         = nm_rdata.nxt;
        nm_re        = 1'b1;
        nm_raddr     = nm_rdata.nxt;
        rmw_nxt_d    = 1'b0;
        rmw_val_d    = s_q;
        wnew_d       = 1'b1;
        state_d      = S_RMW;
      end

      S_RMW: begin
        nm_we    = 1'b1;
        nm_waddr = raddr_q;
        nm_wdata = rmw_word;
        if (sec_q) begin
          nm_re     = 1'b1;
          nm_raddr  = sec_addr_q;
          rmw_nxt_d = sec_nxt_q;
          rmw_val_d = sec_val_q;
          sec_d     = 1'b0;
        end else if (wnew_q) begin
          state_d = S_WNEW;
        end else begin
          state_d = S_DONE;
        end
      end

      S_WNEW: begin
        nm_we          = 1'b1;
        nm_waddr       = s_q;
        nm_wdata.value = val_q;
        nm_wdata.nxt   = nb_q;
        nm_wdata.prv   = ref_q;
        nm_wdata.used  = 1'b1;
        wnew_d         = 1'b0;
        state_d        = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d.status       = st_q;
          out_d.handle_out   = HDL_W'(hout);
          out_d.handle_valid = hvalid;
          out_d.list_count   = CNT_W'(cnt_q);
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      ftop_q      <= CW'(SLOTS);
      lw_q        <= CW'(SLOTS);
      out_valid_q <= 1'b0;
      sec_q       <= 1'b0;
      wnew_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      ftop_q      <= ftop_d;
      lw_q        <= lw_d;
      out_valid_q <= out_valid_d;
      sec_q       <= sec_d;
      wnew_q      <= wnew_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    hin_q      <= hin_d;
    before_q   <= before_d;
    del_q      <= del_d;
    s_q        <= s_d;
    ref_q      <= ref_d;
    nb_q       <= nb_d;
    steps_q    <= steps_d;
    hops_q     <= hops_d;
    lk_q       <= lk_d;
    hsel_q     <= hsel_d;
    st_q       <= st_d;
    rmw_nxt_q  <= rmw_nxt_d;
    rmw_val_q  <= rmw_val_d;
    sec_addr_q <= sec_addr_d;
    sec_nxt_q  <= sec_nxt_d;
    sec_val_q  <= sec_val_d;
    out_q      <= out_d;
    if (nm_re) begin
      raddr_q  <= nm_raddr;
      // slots at or above SLOTS - lw_q were never handed out: not in use
      rvalid_q <= (32'(nm_raddr) < (SLOTS - 32'(lw_q)));
    end
  end

  // every slot is either on the free stack or in the list
  `BDLL_ASSERT(a_slot_balance, (32'(ftop_q) + 32'(cnt_q)) == SLOTS)
  `BDLL_ASSERT(a_low_water, lw_q <= ftop_q)
  `BDLL_ASSERT(a_pop_nonempty, (state_q == S_POPW) |-> (ftop_q != '0))
  `BDLL_ASSERT(a_rsp_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE))

endmodule

`default_nettype wire

>>> rtl/bdll_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Node RAM, one write and one read port, registered read.
// A read of the address written in the same cycle returns the new word.
module bdll_node_mem #(
  parameter int  DEPTH  = 1024,
  parameter type word_t = logic
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  word_t                    wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output word_t                    rdata_o
);

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
